@@ hw/rtl/sorted_slot_node_table_defines.svh @@
// ----------------------------------------------------------------------------
// sorted slot node table assertion macros
// shared property forms for the checker of the node table
// ----------------------------------------------------------------------------
`ifndef SORTED_SLOT_NODE_TABLE_DEFINES_SVH
`define SORTED_SLOT_NODE_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SSNT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssnt same-cycle property failed");

// next-cycle implication, disabled while reset is asserted
`define SSNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssnt next-cycle property failed");

`endif

@@ hw/rtl/ssnt_pkg.sv @@
// ----------------------------------------------------------------------------
// ssnt_pkg
// types and codes shared by the sorted slot node table modules
// ----------------------------------------------------------------------------
`default_nettype none

package ssnt_pkg;

  // fixed field widths of the transaction payloads
  localparam int unsigned KeyWidth   = 64;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned IndexWidth = 6;
  localparam int unsigned CountWidth = 6;

  // command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEARCH,
    ST_ACT,
    ST_LOOK
  } state_e;

  // per-cell load selection
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD_NEW
  } cell_op_e;

  // control from the sequencer to one cell
  typedef struct packed {
    logic     cmp_en;
    cell_op_e op;
  } cell_ctl_t;

  // request transaction
  typedef struct packed {
    cmd_e                  command;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
  } req_t;

  // result transaction
  typedef struct packed {
    status_e               status;
    logic [ValueWidth-1:0] found_value;
    logic [IndexWidth-1:0] entry_index;
    logic [CountWidth-1:0] entry_count;
  } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssnt_cell.sv @@
// ----------------------------------------------------------------------------
// ssnt_cell
// one order position: holds the entry index and key at that position,
// compares its key with the search key, and loads the new entry or loads from either neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module ssnt_cell #(
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned ENTRY_BITS = 6
) (
  input  logic                  clk_i,
  input  ssnt_pkg::cell_ctl_t   ctl_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [ENTRY_BITS-1:0] entry_i,
  input  logic [KEY_BITS-1:0]   left_key_i,
  input  logic [ENTRY_BITS-1:0] left_entry_i,
  input  logic [KEY_BITS-1:0]   right_key_i,
  input  logic [ENTRY_BITS-1:0] right_entry_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [ENTRY_BITS-1:0] entry_o,
  output logic                  gt_o,
  output logic                  lt_o
);

  logic [KEY_BITS-1:0]   key_q;
  logic [ENTRY_BITS-1:0] entry_q;
  logic                  gt_q;
  logic                  lt_q;

  // position contents, shifted along the row on insert and delete
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      ssnt_pkg::CELL_HOLD: begin
        key_q   <= key_q;
        entry_q <= entry_q;
      end
      ssnt_pkg::CELL_FROM_LEFT: begin
        key_q   <= left_key_i;
        entry_q <= left_entry_i;
      end
      ssnt_pkg::CELL_FROM_RIGHT: begin
        key_q   <= right_key_i;
        entry_q <= right_entry_i;
      end
      ssnt_pkg::CELL_LOAD_NEW: begin
        key_q   <= key_i;
        entry_q <= entry_i;
      end
      default: begin
        key_q   <= key_q;
        entry_q <= entry_q;
      end
    endcase
  end

  // stored compare flags for the search sequencer
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp_en) begin
      gt_q <= (key_q > key_i);
      lt_q <= (key_q < key_i);
    end
  end

  assign key_o   = key_q;
  assign entry_o = entry_q;
  assign gt_o    = gt_q;
  assign lt_o    = lt_q;

endmodule

`default_nettype wire

@@ hw/rtl/ssnt_vmem.sv @@
// ----------------------------------------------------------------------------
// ssnt_vmem
// value store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ssnt_vmem #(
  parameter int unsigned DEPTH     = 63,
  parameter int unsigned ADDR_BITS = 6,
  parameter int unsigned DATA_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_slot_node_table.sv @@
// ----------------------------------------------------------------------------
// sorted_slot_node_table
// one leaf node of a slot-array tree: entry store, valid map and a row of
// order cells kept in ascending key order
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction (insert, delete, lookup, update) is taken on req_i
//   at a clock edge where start is high and busy is low. busy stays high
//   until the result is shown. The result is on rsp_o, marked by done_o
//   for exactly one cycle; the receiver cannot hold it off, and a new
//   command may be started in that same cycle.
//   Sequence: the ST_CMP state loads the compare flags of all order cells
//   at once, then the binary search probes one order position per cycle,
//   plus a last search step that settles the position when the key is
//   missing; the ST_ACT state applies the shift and the writes, and a
//   lookup that finds its key spends the ST_LOOK state on the value store
//   read.
//   Reset empties the node: count zero and every entry free. Key, value and
//   order contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_slot_node_table #(
  parameter int unsigned NODE_ENTRIES = 63,
  parameter int unsigned KEY_BITS     = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  ssnt_pkg::req_t  req_i,
  output logic            busy,
  output logic            done_o,
  output ssnt_pkg::rsp_t  rsp_o
);

  localparam int unsigned EntryBits = $clog2(NODE_ENTRIES);
  localparam int unsigned CountBits = $clog2(NODE_ENTRIES + 1);
  localparam int unsigned PosBits   = $clog2(NODE_ENTRIES + 2);
  localparam int unsigned ValBits   = ssnt_pkg::ValueWidth;

  ssnt_pkg::state_e       state_q, state_d;
  ssnt_pkg::cmd_e         cmd_q, cmd_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [ValBits-1:0]     value_q, value_d;
  logic [CountBits-1:0]   count_q, count_d;
  logic [NODE_ENTRIES-1:0] valid_q, valid_d;
  logic [EntryBits-1:0]   free_q, free_d;
  logic [PosBits-1:0]     lo_q, lo_d;
  logic [PosBits-1:0]     hi_q, hi_d;
  logic [PosBits-1:0]     mid_q, mid_d;
  logic [PosBits-1:0]     pos_q, pos_d;
  logic                   hit_q, hit_d;
  ssnt_pkg::rsp_t         rsp_q, rsp_d;
  logic                   done_q, done_d;

  logic                   accept;
  logic                   ins_go;
  logic                   del_go;
  logic                   search_go;
  logic [PosBits:0]       mid_sum;
  logic [PosBits-1:0]     mid_calc;
  logic [EntryBits-1:0]   probe;
  logic                   probe_gt;
  logic                   probe_lt;
  logic                   search_end;
  logic [EntryBits-1:0]   sel_idx;
  logic [EntryBits-1:0]   sel_entry;
  logic [PosBits-1:0]     count_ext;

  logic [KEY_BITS-1:0]    cell_key   [NODE_ENTRIES];
  logic [EntryBits-1:0]   cell_entry [NODE_ENTRIES];
  logic [NODE_ENTRIES-1:0] gt_vec;
  logic [NODE_ENTRIES-1:0] lt_vec;

  logic                   mem_we;
  logic [EntryBits-1:0]   mem_waddr;
  logic [ValBits-1:0]     mem_rdata;

  assign accept    = start && !busy;
  assign ins_go    = (cmd_q == ssnt_pkg::CMD_INSERT) &&
                     (count_q != CountBits'(NODE_ENTRIES));
  assign del_go    = (cmd_q == ssnt_pkg::CMD_DELETE) && hit_q;
  assign count_ext = PosBits'(count_q);

  // lowest free entry
  always_comb begin
    free_d = '0;
    for (int i = NODE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_d = EntryBits'(i);
      end
    end
  end

  // binary search probe over the stored compare flags
  assign search_go  = (lo_q <= hi_q);
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_calc   = PosBits'(mid_sum >> 1);
  assign probe      = EntryBits'(mid_calc - PosBits'(1));
  assign probe_gt   = gt_vec[probe];
  assign probe_lt   = lt_vec[probe];
  assign search_end = (state_q == ssnt_pkg::ST_SEARCH) &&
                      (!search_go || (!probe_gt && !probe_lt));

  // entry named by the found position
  assign sel_idx   = hit_q ? EntryBits'(pos_q - PosBits'(1)) : '0;
  assign sel_entry = cell_entry[sel_idx];

  // row of order cells
  for (genvar c = 0; c < NODE_ENTRIES; c++) begin : g_cell
    localparam logic [PosBits-1:0] CellPos = PosBits'(c + 1);

    ssnt_pkg::cell_ctl_t  ctl;
    logic [KEY_BITS-1:0]  left_key;
    logic [EntryBits-1:0] left_entry;
    logic [KEY_BITS-1:0]  right_key;
    logic [EntryBits-1:0] right_entry;

    if (c == 0) begin : g_first
      assign left_key   = key_q;
      assign left_entry = free_q;
    end else begin : g_left
      assign left_key   = cell_key[c-1];
      assign left_entry = cell_entry[c-1];
    end

    if (c == NODE_ENTRIES - 1) begin : g_last
      assign right_key   = cell_key[c];
      assign right_entry = cell_entry[c];
    end else begin : g_right
      assign right_key   = cell_key[c+1];
      assign right_entry = cell_entry[c+1];
    end

    // per-cell load selection for the shift
    always_comb begin
      ctl.cmp_en = (state_q == ssnt_pkg::ST_CMP);
      ctl.op     = ssnt_pkg::CELL_HOLD;
      if (state_q == ssnt_pkg::ST_ACT) begin
        if (ins_go) begin
          if (CellPos == pos_q) begin
            ctl.op = ssnt_pkg::CELL_LOAD_NEW;
          end else if ((CellPos > pos_q) && (CellPos <= count_ext + PosBits'(1))) begin
            ctl.op = ssnt_pkg::CELL_FROM_LEFT;
          end
        end else if (del_go) begin
          if ((CellPos >= pos_q) && (CellPos < count_ext)) begin
            ctl.op = ssnt_pkg::CELL_FROM_RIGHT;
          end
        end
      end
    end

    ssnt_cell #(
      .KEY_BITS   (KEY_BITS),
      .ENTRY_BITS (EntryBits)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .key_i         (key_q),
      .entry_i       (free_q),
      .left_key_i    (left_key),
      .left_entry_i  (left_entry),
      .right_key_i   (right_key),
      .right_entry_i (right_entry),
      .key_o         (cell_key[c]),
      .entry_o       (cell_entry[c]),
      .gt_o          (gt_vec[c]),
      .lt_o          (lt_vec[c])
    );
  end

  // value store
  assign mem_we    = (state_q == ssnt_pkg::ST_ACT) &&
                     (ins_go || (hit_q && (cmd_q == ssnt_pkg::CMD_UPDATE)));
  assign mem_waddr = ins_go ? free_q : sel_entry;

  ssnt_vmem #(
    .DEPTH     (NODE_ENTRIES),
    .ADDR_BITS (EntryBits),
    .DATA_BITS (ValBits)
  ) u_vmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (value_q),
    .raddr_i (sel_entry),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssnt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = ssnt_pkg::ST_CMP;
        end
      end
      ssnt_pkg::ST_CMP: begin
        state_d = ssnt_pkg::ST_SEARCH;
      end
      ssnt_pkg::ST_SEARCH: begin
        if (search_end) begin
          state_d = ssnt_pkg::ST_ACT;
        end
      end
      ssnt_pkg::ST_ACT: begin
        if ((cmd_q == ssnt_pkg::CMD_LOOKUP) && hit_q) begin
          state_d = ssnt_pkg::ST_LOOK;
        end else begin
          state_d = ssnt_pkg::ST_IDLE;
        end
      end
      ssnt_pkg::ST_LOOK: begin
        state_d = ssnt_pkg::ST_IDLE;
      end
      default: begin
        state_d = ssnt_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy = (state_q != ssnt_pkg::ST_IDLE);
  end

  // datapath next values
  always_comb begin
    cmd_d   = cmd_q;
    key_d   = key_q;
    value_d = value_q;
    count_d = count_q;
    valid_d = valid_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    pos_d   = pos_q;
    hit_d   = hit_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    unique case (state_q)
      ssnt_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d   = req_i.command;
          key_d   = req_i.key[KEY_BITS-1:0];
          value_d = req_i.value;
        end
      end
      ssnt_pkg::ST_CMP: begin
        lo_d  = PosBits'(1);
        hi_d  = count_ext;
        mid_d = PosBits'(1);
        hit_d = 1'b0;
      end
      ssnt_pkg::ST_SEARCH: begin
        if (search_go) begin
          mid_d = mid_calc;
          if (probe_gt) begin
            hi_d = mid_calc - PosBits'(1);
          end else if (probe_lt) begin
            lo_d = mid_calc + PosBits'(1);
          end else begin
            hit_d = 1'b1;
            pos_d = mid_calc;
          end
        end else begin
          pos_d = (lo_q > mid_q) ? lo_q : mid_q;
        end
      end
      ssnt_pkg::ST_ACT: begin
        rsp_d        = '0;
        rsp_d.status = ssnt_pkg::STATUS_DONE;
        if (cmd_q == ssnt_pkg::CMD_INSERT) begin
          if (ins_go) begin
            valid_d[free_q]   = 1'b1;
            count_d           = count_q + CountBits'(1);
            rsp_d.entry_index = ssnt_pkg::IndexWidth'(free_q);
          end else begin
            rsp_d.status = ssnt_pkg::STATUS_FULL;
          end
        end else if (!hit_q) begin
          rsp_d.status = ssnt_pkg::STATUS_NOT_FOUND;
        end else begin
          rsp_d.entry_index = ssnt_pkg::IndexWidth'(sel_entry);
          case (cmd_q)
            ssnt_pkg::CMD_DELETE: begin
              valid_d[sel_entry] = 1'b0;
              count_d            = count_q - CountBits'(1);
            end
            ssnt_pkg::CMD_UPDATE: begin
              rsp_d.found_value = value_q;
            end
            default: begin
              rsp_d.found_value = '0;
            end
          endcase
        end
        rsp_d.entry_count = ssnt_pkg::CountWidth'(count_d);
        done_d = !((cmd_q == ssnt_pkg::CMD_LOOKUP) && hit_q);
      end
      ssnt_pkg::ST_LOOK: begin
        rsp_d.found_value = mem_rdata;
        done_d            = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssnt_pkg::ST_IDLE;
      count_q <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    value_q <= value_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    pos_q   <= pos_d;
    hit_q   <= hit_d;
    rsp_q   <= rsp_d;
    if (state_q == ssnt_pkg::ST_CMP) begin
      free_q <= free_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

@@ hw/rtl/ssnt_checker.sv @@
// ----------------------------------------------------------------------------
// ssnt_checker
// port-level properties of the sorted slot node table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_slot_node_table_defines.svh"

module ssnt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_i,
  input ssnt_pkg::rsp_t rsp_i
);

  // an accepted command keeps the block busy
  `SSNT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // the result shows in the cycle the block turns free again
  `SSNT_ASSERT_IMPL(a_done_free, clk_i, rst_ni, done_i, !busy)
  `SSNT_ASSERT_IMPL(a_free_done, clk_i, rst_ni, $fell(busy), done_i)

  // one result per transaction
  `SSNT_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_i, !done_i)

  // failed commands report no entry and no value
  `SSNT_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, done_i && (rsp_i.status != ssnt_pkg::STATUS_DONE), (rsp_i.found_value == '0) && (rsp_i.entry_index == '0))

endmodule

bind sorted_slot_node_table ssnt_checker u_ssnt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_i (done_o),
  .rsp_i  (rsp_o)
);

`default_nettype wire
